>>> design/assert_macros.svh
// Assertion macros used by the top level of the allocator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed in the allocator");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed in the allocator");

`endif

>>> design/pfa_pkg.sv
// Package of constants, codes and control types for the paged block allocator.
`default_nettype none

package pfa_pkg;

  // Memory geometry.
  localparam int PAGE_BYTES      = 4096;
  localparam int BLOCK_BYTES     = 32;
  localparam int PAGES           = 8;
  localparam int BLOCKS_PER_PAGE = PAGE_BYTES / BLOCK_BYTES;
  localparam int TOTAL_BLOCKS    = PAGES * BLOCKS_PER_PAGE;
  localparam int FREE_MAX        = 2047;

  // Field widths.
  localparam int FUNC_W   = 2;
  localparam int SIZE_W   = 16;
  localparam int BLK_W    = 10;
  localparam int LINK_W   = 11;
  localparam int CNT_W    = 11;
  localparam int STATUS_W = 3;
  localparam int PAGES_W  = 4;
  localparam int FILL_W   = (BLOCKS_PER_PAGE > 1) ? $clog2(BLOCKS_PER_PAGE) : 1;

  localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(TOTAL_BLOCKS);

  // Operation codes.
  localparam logic [FUNC_W-1:0] FN_ALLOC  = 2'd0;
  localparam logic [FUNC_W-1:0] FN_FREE   = 2'd1;
  localparam logic [FUNC_W-1:0] FN_REFILL = 2'd2;

  // Status codes.
  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_TOO_LARGE = 3'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd2;
  localparam logic [STATUS_W-1:0] ST_REFILLED  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_IDLE      = 3'd4;
  localparam logic [STATUS_W-1:0] ST_DRAINED   = 3'd5;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;     // take the input word and decode it
    logic alloc_ld;   // load the head from the link read data
    logic fill_step;  // write one link of the page being chained
    logic out_load;   // move the pending result into the output register
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic start_alloc;  // accepted word is an allocate that succeeds
    logic start_fill;   // accepted word is a refill that chains a page
    logic fill_last;    // current fill step writes the last link of the page
    logic out_free;     // output register can take a result this cycle
  } ctrl_sts_t;

endpackage

`default_nettype wire

>>> design/pfa_if.sv
// Handshake interfaces for the request and result channels.
`default_nettype none

interface pfa_in_if;
  import pfa_pkg::*;

  logic                valid;
  logic                ready;
  logic [FUNC_W-1:0]   func;
  logic [SIZE_W-1:0]   request_size;
  logic [BLK_W-1:0]    block_index;

  modport source (output valid, output func, output request_size, output block_index,
                  input ready);
  modport sink   (input valid, input func, input request_size, input block_index,
                  output ready);
endinterface

interface pfa_out_if;
  import pfa_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [BLK_W-1:0]    granted_block;
  logic [CNT_W-1:0]    blocks_free;
  logic [PAGES_W-1:0]  pages_in_use;

  modport source (output valid, output status, output granted_block, output blocks_free,
                  output pages_in_use, input ready);
  modport sink   (input valid, input status, input granted_block, input blocks_free,
                  input pages_in_use, output ready);
endinterface

`default_nettype wire

>>> design/pfa_ram.sv
// Generic single-port RAM with a registered read.
`default_nettype none

module pfa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] addr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // One address a cycle: an optional write, and a read of the old word into the output register.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

`default_nettype wire

>>> design/pfa_ctrl.sv
// Controller state machine of the paged block allocator.
`default_nettype none

module pfa_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire pfa_pkg::ctrl_sts_t sts_i,
  output pfa_pkg::ctrl_cmd_t      cmd_o
);
  import pfa_pkg::*;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_ALLOC,
    S_FILL,
    S_DONE
  } state_e;

  state_e state_q, state_d;

  // Commands follow from the state alone, but for the accept strobe and the output load.
  always_comb begin
    cmd_o           = '0;
    in_ready_o      = 1'b0;
    state_d         = state_q;
    unique case (state_q)
      S_INIT: begin
        cmd_o.fill_step = 1'b1;
        if (sts_i.fill_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
        if (in_valid_i) begin
          priority if (sts_i.start_alloc) begin
            state_d = S_ALLOC;
          end else if (sts_i.start_fill) begin
            state_d = S_FILL;
          end else begin
            state_d = S_DONE;
          end
        end
      end
      S_ALLOC: begin
        cmd_o.alloc_ld = 1'b1;
        state_d        = S_DONE;
      end
      S_FILL: begin
        cmd_o.fill_step = 1'b1;
        if (sts_i.fill_last) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        cmd_o.out_load = sts_i.out_free;
        if (sts_i.out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State register; reset starts by chaining page zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

>>> design/pfa_dp.sv
// Datapath of the paged block allocator: list registers, link memory and result.
`default_nettype none

module pfa_dp (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire pfa_pkg::ctrl_cmd_t              cmd_i,
  output pfa_pkg::ctrl_sts_t                   sts_o,
  input  wire logic [pfa_pkg::FUNC_W-1:0]      func_i,
  input  wire logic [pfa_pkg::SIZE_W-1:0]      request_size_i,
  input  wire logic [pfa_pkg::BLK_W-1:0]       block_index_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output logic      [pfa_pkg::STATUS_W-1:0]    status_o,
  output logic      [pfa_pkg::BLK_W-1:0]       granted_block_o,
  output logic      [pfa_pkg::CNT_W-1:0]       blocks_free_o,
  output logic      [pfa_pkg::PAGES_W-1:0]     pages_in_use_o
);
  import pfa_pkg::*;

  // List state and the page sequencer.
  logic [LINK_W-1:0]   head_q, head_d;
  logic [CNT_W-1:0]    free_q, free_d;
  logic [PAGES_W-1:0]  pages_q, pages_d;
  logic [LINK_W-1:0]   fill_base_q, fill_base_d;
  logic [BLK_W-1:0]    fill_addr_q, fill_addr_d;
  logic [FILL_W-1:0]   fill_cnt_q, fill_cnt_d;

  // Pending result of the word in flight.
  logic [STATUS_W-1:0] res_status_q, res_status_d;
  logic [BLK_W-1:0]    res_granted_q, res_granted_d;

  // Output register.
  logic                out_valid_q;
  logic [STATUS_W-1:0] out_status_q;
  logic [BLK_W-1:0]    out_granted_q;
  logic [CNT_W-1:0]    out_free_q;
  logic [PAGES_W-1:0]  out_pages_q;

  // Link memory port.
  logic                ram_we;
  logic [BLK_W-1:0]    ram_addr;
  logic [LINK_W-1:0]   ram_wdata;
  logic [LINK_W-1:0]   ram_rdata;

  logic too_large, list_empty, blk_in_range, pages_left, fill_last;

  // Decode of the word offered at the input.
  assign too_large    = {1'b0, request_size_i} > (SIZE_W + 1)'(BLOCK_BYTES);
  assign list_empty   = (free_q == '0) || (head_q >= NULL_LINK);
  assign blk_in_range = {1'b0, block_index_i} < NULL_LINK;
  assign pages_left   = pages_q < PAGES_W'(PAGES);
  assign fill_last    = fill_cnt_q == FILL_W'(BLOCKS_PER_PAGE - 1);

  assign sts_o.start_alloc = (func_i == FN_ALLOC) && !too_large && !list_empty;
  assign sts_o.start_fill  = (func_i == FN_REFILL) && (free_q == '0) && pages_left;
  assign sts_o.fill_last   = fill_last;
  assign sts_o.out_free    = !out_valid_q || out_ready_i;

  // Link memory: chain writes, free pushes, and the head read of an allocate.
  always_comb begin
    ram_we    = 1'b0;
    ram_addr  = head_q[BLK_W-1:0];
    ram_wdata = head_q;
    priority if (cmd_i.fill_step) begin
      ram_we    = 1'b1;
      ram_addr  = fill_addr_q;
      ram_wdata = fill_last ? NULL_LINK : ({1'b0, fill_addr_q} + LINK_W'(1));
    end else if (cmd_i.accept && (func_i == FN_FREE) && blk_in_range) begin
      ram_we    = 1'b1;
      ram_addr  = block_index_i;
      ram_wdata = head_q;
    end else begin
      ram_we    = 1'b0;
    end
  end

  pfa_ram #(
    .WIDTH (LINK_W),
    .DEPTH (TOTAL_BLOCKS)
  ) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  // Next state of the list, the sequencer and the pending result.
  always_comb begin
    head_d        = head_q;
    free_d        = free_q;
    pages_d       = pages_q;
    fill_base_d   = fill_base_q;
    fill_addr_d   = fill_addr_q;
    fill_cnt_d    = fill_cnt_q;
    res_status_d  = res_status_q;
    res_granted_d = res_granted_q;

    if (cmd_i.accept) begin
      res_status_d  = ST_IDLE;
      res_granted_d = '0;
      unique case (func_i)
        FN_ALLOC: begin
          priority if (too_large) begin
            res_status_d = ST_TOO_LARGE;
          end else if (list_empty) begin
            res_status_d = ST_EMPTY;
          end else begin
            res_status_d  = ST_OK;
            res_granted_d = head_q[BLK_W-1:0];
            free_d        = free_q - CNT_W'(1);
          end
        end
        FN_FREE: begin
          if (blk_in_range) begin
            res_status_d = ST_OK;
            head_d       = {1'b0, block_index_i};
            if (free_q < CNT_W'(FREE_MAX)) begin
              free_d = free_q + CNT_W'(1);
            end
          end
        end
        FN_REFILL: begin
          if (free_q == '0) begin
            res_status_d = pages_left ? ST_REFILLED : ST_DRAINED;
          end
        end
        default: begin
          res_status_d = ST_IDLE;
        end
      endcase
    end

    // The link of the old head arrives from the registered read, in the cycle after the read.
    if (cmd_i.alloc_ld) begin
      head_d = ram_rdata;
    end

    // One link per cycle; the last one hands the page over as the list.
    if (cmd_i.fill_step) begin
      fill_addr_d = fill_addr_q + BLK_W'(1);
      fill_cnt_d  = fill_cnt_q + FILL_W'(1);
      if (fill_last) begin
        fill_cnt_d  = '0;
        head_d      = fill_base_q;
        free_d      = CNT_W'(BLOCKS_PER_PAGE);
        pages_d     = pages_q + PAGES_W'(1);
        fill_base_d = fill_base_q + LINK_W'(BLOCKS_PER_PAGE);
      end
    end
  end

  // State registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      free_q      <= '0;
      pages_q     <= '0;
      fill_base_q <= '0;
      fill_addr_q <= '0;
      fill_cnt_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      head_q      <= head_d;
      free_q      <= free_d;
      pages_q     <= pages_d;
      fill_base_q <= fill_base_d;
      fill_addr_q <= fill_addr_d;
      fill_cnt_q  <= fill_cnt_d;
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers of the pending and the delivered result.
  always_ff @(posedge clk_i) begin
    res_status_q  <= res_status_d;
    res_granted_q <= res_granted_d;
    if (cmd_i.out_load) begin
      out_status_q  <= res_status_q;
      out_granted_q <= res_granted_q;
      out_free_q    <= free_q;
      out_pages_q   <= pages_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = out_status_q;
  assign granted_block_o = out_granted_q;
  assign blocks_free_o   = out_free_q;
  assign pages_in_use_o  = out_pages_q;

endmodule

`default_nettype wire

>>> design/paged_free_list_block_allocator.sv
// Top level of the paged free-list block allocator.
//
// Fixed-size block allocator: free blocks are kept as a linked list in a
// 1024-entry link memory. One request word is taken at a time; a word is
// accepted while the previous result still waits in the output register.
// Free, refused allocates, refill ticks that do nothing and unknown codes pass
// from acceptance through the pending result register to the output register.
// A successful allocate also passes the allocate state, as the next head comes
// from the registered read of the link memory. A refill that chains a new page
// writes one link a cycle through the single memory port, and its result
// follows once the last link of the page is written. A result that is not
// taken holds the next word in the block until the output register frees.
// After reset the block chains page zero the same way, which holds ready low
// while it runs.
`default_nettype none
`include "assert_macros.svh"

module paged_free_list_block_allocator (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  pfa_in_if.sink    in_i,
  pfa_out_if.source out_o
);
  import pfa_pkg::*;

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;
  logic      in_ready;

  pfa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  pfa_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .func_i          (in_i.func),
    .request_size_i  (in_i.request_size),
    .block_index_i   (in_i.block_index),
    .out_valid_o     (out_o.valid),
    .out_ready_i     (out_o.ready),
    .status_o        (out_o.status),
    .granted_block_o (out_o.granted_block),
    .blocks_free_o   (out_o.blocks_free),
    .pages_in_use_o  (out_o.pages_in_use)
  );

  assign in_i.ready = in_ready;

  // A refill that chains a page holds the input off while the links are written.
  `ASSERT_NEXT(a_fill_blocks_input, clk_i, rst_ni, cmd.accept && sts.start_fill, !in_ready)

  // Only a successful allocate names a block.
  `ASSERT_SAME(a_grant_only_on_ok, clk_i, rst_ni, out_o.valid && (out_o.status != ST_OK), out_o.granted_block == '0)

  // A delivered result always reports at least one page and no more than exist.
  `ASSERT_SAME(a_pages_in_range, clk_i, rst_ni, out_o.valid, (out_o.pages_in_use != '0) && (out_o.pages_in_use <= PAGES_W'(PAGES)))

  // A word is never taken in the same cycle as a link is chained.
  `ASSERT_SAME(a_no_accept_in_fill, clk_i, rst_ni, cmd.fill_step, !cmd.accept && !cmd.out_load)

endmodule

`default_nettype wire
